// ----- sv/ppsm_pkg.sv -----
// ppsm_pkg: shared types, constants and codes for the photogate pair speed meter
// used by ppsm_div, ppsm_dp, ppsm_ctrl and photogate_pair_speed_meter; no dependencies
`default_nettype none

package ppsm_pkg;

  localparam int unsigned NUM_GATES   = 4;
  localparam int unsigned GATE_IDX_W  = 2;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned TS_W        = 32;
  localparam int unsigned PASS_W      = 2;
  localparam int unsigned SPACING_W   = 7;
  localparam int unsigned SPEED_W     = 17;
  localparam int unsigned SPEED_SCALE = 1000;
  localparam int unsigned DIV_CNT_W   = $clog2(SPEED_W);
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [PASS_W-1:0] PASS_MAX  = 2'd3;
  localparam logic [PASS_W-1:0] PASS_ONE  = 2'd1;
  localparam logic [CMD_W-1:0]  CMD_CLEAR = 3'd4;

  // register index, taken from paddr[2]
  localparam logic REG_SPACING = 1'b0;
  localparam logic REG_DIR     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_DIV_A,
    ST_LOAD_B,
    ST_DIV_B,
    ST_PUBLISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic update;   // apply the accepted beat to the gate state
    logic load_a;   // evaluate pair a and start its division
    logic load_b;   // keep pair a speed, evaluate pair b and start its division
    logic publish;  // move both pair results into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

  typedef struct packed {
    logic              valid;
    logic [PASS_W-1:0] slot;
    logic              negative;
    logic              zero_interval;
  } pair_info_t;

endpackage

`default_nettype wire

// ----- sv/ppsm_div.sv -----
// ppsm_div: restoring divider, one quotient bit per cycle
// depends on ppsm_pkg
`default_nettype none

module ppsm_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ppsm_pkg::SPEED_W-1:0]   num,
  input  wire logic [ppsm_pkg::TS_W-1:0]      den,
  output logic                                done,
  output logic [ppsm_pkg::SPEED_W-1:0]        quot
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [ppsm_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [ppsm_pkg::TS_W-1:0]          den_r, den_nxt;
  logic [ppsm_pkg::TS_W-1:0]          rem_r, rem_nxt;
  logic [ppsm_pkg::SPEED_W-1:0]       quot_r, quot_nxt;
  logic [ppsm_pkg::TS_W:0]            rem_sh;
  logic [ppsm_pkg::TS_W:0]            diff;
  logic                               fits;
  logic                               last_step;

  always_comb begin
    rem_sh    = {rem_r, quot_r[ppsm_pkg::SPEED_W-1]};
    diff      = rem_sh - {1'b0, den_r};
    fits      = !diff[ppsm_pkg::TS_W];
    last_step = (cnt_r == ppsm_pkg::DIV_CNT_W'(ppsm_pkg::SPEED_W - 1));

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = num;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[ppsm_pkg::TS_W-1:0] : rem_sh[ppsm_pkg::TS_W-1:0];
      quot_nxt = {quot_r[ppsm_pkg::SPEED_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ----- sv/ppsm_dp.sv -----
// ppsm_dp: gate state, configuration registers, pair evaluation and output register
// depends on ppsm_pkg and ppsm_div
`default_nettype none

module ppsm_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [ppsm_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [ppsm_pkg::TS_W-1:0]         in_timestamp_us,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ppsm_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [ppsm_pkg::DATA_W-1:0]       pwdata,
  output logic [ppsm_pkg::DATA_W-1:0]            prdata,
  input  wire ppsm_pkg::ctrl_cmd_t               cmd,
  output ppsm_pkg::dp_status_t                   status,
  output logic                                   out_a_valid,
  output logic [ppsm_pkg::PASS_W-1:0]            out_a_slot,
  output logic [ppsm_pkg::SPEED_W-1:0]           out_a_speed,
  output logic                                   out_a_negative,
  output logic                                   out_a_zero_interval,
  output logic                                   out_b_valid,
  output logic [ppsm_pkg::PASS_W-1:0]            out_b_slot,
  output logic [ppsm_pkg::SPEED_W-1:0]           out_b_speed,
  output logic                                   out_b_negative,
  output logic                                   out_b_zero_interval
);

  logic [ppsm_pkg::TS_W-1:0]      gate_time_r  [ppsm_pkg::NUM_GATES];
  logic [ppsm_pkg::PASS_W-1:0]    gate_count_r [ppsm_pkg::NUM_GATES];
  logic [ppsm_pkg::SPACING_W-1:0] spacing_r;
  logic                           dir_r;
  logic                           cfg_wr;

  logic [ppsm_pkg::GATE_IDX_W-1:0] gate_idx;
  logic [ppsm_pkg::PASS_W-1:0]     count_inc;

  logic [ppsm_pkg::TS_W-1:0]      t_first, t_second, diff;
  logic [ppsm_pkg::PASS_W-1:0]    c_first, c_second;
  logic                           forward;
  logic [ppsm_pkg::SPEED_W-1:0]   scaled;
  ppsm_pkg::pair_info_t           pair_eval;
  ppsm_pkg::pair_info_t           a_info_r, b_info_r;
  logic [ppsm_pkg::SPEED_W-1:0]   a_speed_r;
  logic [ppsm_pkg::SPEED_W-1:0]   quot, quot_masked;
  logic                           div_done;

  ppsm_pkg::pair_info_t           out_a_r, out_b_r;
  logic [ppsm_pkg::SPEED_W-1:0]   out_a_speed_r, out_b_speed_r;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= ppsm_pkg::SPACING_W'(7);
      dir_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ppsm_pkg::REG_SPACING: spacing_r <= pwdata[ppsm_pkg::SPACING_W-1:0];
        ppsm_pkg::REG_DIR:     dir_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ppsm_pkg::REG_SPACING: prdata = ppsm_pkg::DATA_W'(spacing_r);
      ppsm_pkg::REG_DIR:     prdata = ppsm_pkg::DATA_W'(dir_r);
      default:               prdata = '0;
    endcase
  end

  // gate state update
  assign gate_idx  = in_cmd[ppsm_pkg::GATE_IDX_W-1:0];
  assign count_inc = (gate_count_r[gate_idx] == ppsm_pkg::PASS_MAX) ?
                     ppsm_pkg::PASS_ONE : gate_count_r[gate_idx] + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ppsm_pkg::NUM_GATES; i++) begin
        gate_time_r[i]  <= '0;
        gate_count_r[i] <= '0;
      end
    end else if (cmd.update) begin
      if (in_cmd[ppsm_pkg::CMD_W-1] == 1'b0) begin
        gate_time_r[gate_idx]  <= in_timestamp_us;
        gate_count_r[gate_idx] <= count_inc;
      end else if (in_cmd == ppsm_pkg::CMD_CLEAR) begin
        for (int i = 0; i < ppsm_pkg::NUM_GATES; i++) begin
          gate_count_r[i] <= '0;
        end
      end
    end
  end

  // pair evaluation, pair b while load_b is high
  always_comb begin
    t_first  = cmd.load_b ? gate_time_r[2]  : gate_time_r[0];
    t_second = cmd.load_b ? gate_time_r[3]  : gate_time_r[1];
    c_first  = cmd.load_b ? gate_count_r[2] : gate_count_r[0];
    c_second = cmd.load_b ? gate_count_r[3] : gate_count_r[1];
    forward  = t_second > t_first;
    diff     = forward ? (t_second - t_first) : (t_first - t_second);

    pair_eval.valid         = (c_first == c_second) && (c_first != '0);
    pair_eval.slot          = pair_eval.valid ? c_first : '0;
    pair_eval.zero_interval = pair_eval.valid && (diff == '0);
    pair_eval.negative      = pair_eval.valid && (diff != '0) && (forward == dir_r);
  end

  assign scaled = ppsm_pkg::SPEED_W'(32'(spacing_r) * ppsm_pkg::SPEED_SCALE);

  ppsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load_a || cmd.load_b),
    .num   (scaled),
    .den   (diff),
    .done  (div_done),
    .quot  (quot)
  );

  assign status.div_done = div_done;

  // divider runs for every pair; quotient only counts for a valid nonzero interval
  always_comb begin
    if (cmd.load_b) begin
      quot_masked = (a_info_r.valid && !a_info_r.zero_interval) ? quot : '0;
    end else begin
      quot_masked = (b_info_r.valid && !b_info_r.zero_interval) ? quot : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      a_info_r <= pair_eval;
    end
    if (cmd.load_b) begin
      b_info_r  <= pair_eval;
      a_speed_r <= quot_masked;
    end
    if (cmd.publish) begin
      out_a_r       <= a_info_r;
      out_a_speed_r <= a_speed_r;
      out_b_r       <= b_info_r;
      out_b_speed_r <= quot_masked;
    end
  end

  assign out_a_valid         = out_a_r.valid;
  assign out_a_slot          = out_a_r.slot;
  assign out_a_speed         = out_a_speed_r;
  assign out_a_negative      = out_a_r.negative;
  assign out_a_zero_interval = out_a_r.zero_interval;
  assign out_b_valid         = out_b_r.valid;
  assign out_b_slot          = out_b_r.slot;
  assign out_b_speed         = out_b_speed_r;
  assign out_b_negative      = out_b_r.negative;
  assign out_b_zero_interval = out_b_r.zero_interval;

endmodule

`default_nettype wire

// ----- sv/ppsm_ctrl.sv -----
// ppsm_ctrl: sequencing state machine and output valid flag
// depends on ppsm_pkg
`default_nettype none

module ppsm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ppsm_pkg::dp_status_t status,
  output ppsm_pkg::ctrl_cmd_t       cmd
);

  ppsm_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // output register can take a new beat when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppsm_pkg::ST_IDLE:    if (in_valid) state_nxt = ppsm_pkg::ST_LOAD_A;
      ppsm_pkg::ST_LOAD_A:  state_nxt = ppsm_pkg::ST_DIV_A;
      ppsm_pkg::ST_DIV_A:   if (status.div_done) state_nxt = ppsm_pkg::ST_LOAD_B;
      ppsm_pkg::ST_LOAD_B:  state_nxt = ppsm_pkg::ST_DIV_B;
      ppsm_pkg::ST_DIV_B:   if (status.div_done) state_nxt = ppsm_pkg::ST_PUBLISH;
      ppsm_pkg::ST_PUBLISH: if (out_free) state_nxt = ppsm_pkg::ST_IDLE;
      default:              state_nxt = ppsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ppsm_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.update = in_valid;
      end
      ppsm_pkg::ST_LOAD_A:  cmd.load_a  = 1'b1;
      ppsm_pkg::ST_LOAD_B:  cmd.load_b  = 1'b1;
      ppsm_pkg::ST_PUBLISH: cmd.publish = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppsm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/photogate_pair_speed_meter.sv -----
// photogate_pair_speed_meter: top level, joins controller and datapath
// depends on ppsm_pkg, ppsm_ctrl, ppsm_dp (and ppsm_div below it)
//
// usage
//   input channel: one beat per gate event, in_cmd selects the gate (0/1 pair a,
//   2/3 pair b) or clear (4), in_timestamp_us is the event time in microseconds
//   output channel: one beat per input beat carrying both pairs' status, slot,
//   speed (1000 * spacing / interval), sign and zero-interval flag
//   config port: apb-style, register 0 at 0x0 is gate spacing in mm,
//   register 1 at 0x4 is the direction select; pready is tied high
// timing
//   one beat at a time; an accepted beat passes a load step, the divide steps
//   (one quotient bit each) and a done step for pair a, then for pair b, then
//   the publish step into the output register; no new beat is taken before that
//   publish; the shared radix-2 divider works on both pairs in turn
//   in_stall is low only while idle, so the next beat can be taken while the
//   previous result still waits in the output register
// reset
//   synchronous, active low; clears gate times and pass counters, sets spacing
//   to 7 mm and direction to normal, empties the output register
// backpressure
//   when out_stall holds the output beat, a finished result waits in the
//   publish step; the output register never gets overwritten before it is taken
`default_nettype none

module photogate_pair_speed_meter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ppsm_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [ppsm_pkg::TS_W-1:0]         in_timestamp_us,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_a_valid,
  output logic [ppsm_pkg::PASS_W-1:0]            out_a_slot,
  output logic [ppsm_pkg::SPEED_W-1:0]           out_a_speed,
  output logic                                   out_a_negative,
  output logic                                   out_a_zero_interval,
  output logic                                   out_b_valid,
  output logic [ppsm_pkg::PASS_W-1:0]            out_b_slot,
  output logic [ppsm_pkg::SPEED_W-1:0]           out_b_speed,
  output logic                                   out_b_negative,
  output logic                                   out_b_zero_interval,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ppsm_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [ppsm_pkg::DATA_W-1:0]       pwdata,
  output logic [ppsm_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);

  ppsm_pkg::ctrl_cmd_t  cmd;
  ppsm_pkg::dp_status_t status;

  // register access always completes in the access cycle
  assign pready = 1'b1;

  ppsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ppsm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_cmd              (in_cmd),
    .in_timestamp_us     (in_timestamp_us),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .cmd                 (cmd),
    .status              (status),
    .out_a_valid         (out_a_valid),
    .out_a_slot          (out_a_slot),
    .out_a_speed         (out_a_speed),
    .out_a_negative      (out_a_negative),
    .out_a_zero_interval (out_a_zero_interval),
    .out_b_valid         (out_b_valid),
    .out_b_slot          (out_b_slot),
    .out_b_speed         (out_b_speed),
    .out_b_negative      (out_b_negative),
    .out_b_zero_interval (out_b_zero_interval)
  );

  // one beat in flight: an accepted beat closes the input side
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accept");

  // a pending output beat is never overwritten
  a_publish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // divider completes only while a beat is being worked on
  a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> in_stall)
    else $error("divider done while idle");

  // a nonzero speed needs a valid pair with a nonzero interval
  a_speed_a_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_a_speed != '0)) |-> (out_a_valid && !out_a_zero_interval))
    else $error("pair a speed reported without a valid interval");

  a_speed_b_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_b_speed != '0)) |-> (out_b_valid && !out_b_zero_interval))
    else $error("pair b speed reported without a valid interval");

endmodule

`default_nettype wire
